### rtl/core/dual_channel_sample_ring_unit_macros.svh
// Assertion helpers for the sample ring. Both expect clk and rst_n in scope.
`ifndef DUAL_CHANNEL_SAMPLE_RING_UNIT_MACROS_SVH
`define DUAL_CHANNEL_SAMPLE_RING_UNIT_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define DCSR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("dcsr check failed");
// Next-cycle implication.
`define DCSR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("dcsr check failed");
`else
`define DCSR_ASSERT_NOW(lbl, ante, cons)
`define DCSR_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

### rtl/core/dcsr_pkg.sv
`timescale 1ns / 1ps
package dcsr_pkg;

  localparam int RING_SIZE_DEF = 32;
  localparam int BYTE_W        = 8;
  localparam int OP_W          = 2;
  localparam int SAMPLE_W      = 18;
  localparam int OCC_W         = 5;

  localparam logic [3*BYTE_W-1:0] SAMPLE_MASK = 24'h3FFFF;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 2'd0,
    OP_POP   = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NOP   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SEND
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic exec;      // apply the accepted op to pointers and ring
    logic rd_en;     // fetch the entry at the read pointer
    logic out_load;  // capture the result beat
  } ctrl_cmd_t;

  // big-endian 24-bit word, low 18 bits kept
  function automatic logic [SAMPLE_W-1:0] word18(input logic [BYTE_W-1:0] hi,
                                                 input logic [BYTE_W-1:0] mid,
                                                 input logic [BYTE_W-1:0] lo);
    logic [3*BYTE_W-1:0] w;
    w = {hi, mid, lo} & SAMPLE_MASK;
    return w[SAMPLE_W-1:0];
  endfunction

endpackage

### rtl/core/dcsr_in_if.sv
`timescale 1ns / 1ps
interface dcsr_in_if
  import dcsr_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [BYTE_W-1:0] byte_0;
  logic [BYTE_W-1:0] byte_1;
  logic [BYTE_W-1:0] byte_2;
  logic [BYTE_W-1:0] byte_3;
  logic [BYTE_W-1:0] byte_4;
  logic [BYTE_W-1:0] byte_5;

  modport source (
    output valid, opcode, byte_0, byte_1, byte_2, byte_3, byte_4, byte_5,
    input  ready
  );

  modport sink (
    input  valid, opcode, byte_0, byte_1, byte_2, byte_3, byte_4, byte_5,
    output ready
  );
endinterface

### rtl/core/dcsr_out_if.sv
`timescale 1ns / 1ps
interface dcsr_out_if
  import dcsr_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] oldest_red;
  logic [SAMPLE_W-1:0] oldest_ir;
  logic [OCC_W-1:0]    occupancy;

  modport source (
    output valid, oldest_red, oldest_ir, occupancy,
    input  ready
  );

  modport sink (
    input  valid, oldest_red, oldest_ir, occupancy,
    output ready
  );
endinterface

### rtl/core/dual_channel_sample_ring_unit.sv
// Flow: each accepted input beat goes through op, ring read and result load; no
//   new input beat is taken until its result is loaded. A stalled output holds
//   the unit in SEND only while a result still waits in the output register.
// Reset (sync, rst_n low): pointers, fill count and two_ch_r cleared. Ring
//   entries never written since reset read as zero via the fill count; no sweep.
`timescale 1ns / 1ps
module dual_channel_sample_ring_unit
  import dcsr_pkg::*;
#(
  parameter int RING_SIZE = RING_SIZE_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic cfg_we,
  input  logic cfg_wdata,
  dcsr_in_if.sink    in_bus,
  dcsr_out_if.source out_bus
);

  // Controller sequences each beat through three steps:
  //   IDLE: accept beat, apply push/pop/clear to pointers and ring
  //   READ: registered read of the entry under the read pointer
  //   SEND: load the result register once it is free
  ctrl_cmd_t cmd;

  dcsr_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_bus.valid),
    .in_ready  (in_bus.ready),
    .out_valid (out_bus.valid),
    .out_ready (out_bus.ready),
    .cmd       (cmd)
  );

  // Datapath: ring memory (red/ir pair per entry), pointers, fill count,
  // channel-mode register and the result register.
  dcsr_dp #(
    .RING_SIZE (RING_SIZE)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .cmd            (cmd),
    .in_opcode      (in_bus.opcode),
    .in_byte_0      (in_bus.byte_0),
    .in_byte_1      (in_bus.byte_1),
    .in_byte_2      (in_bus.byte_2),
    .in_byte_3      (in_bus.byte_3),
    .in_byte_4      (in_bus.byte_4),
    .in_byte_5      (in_bus.byte_5),
    .out_oldest_red (out_bus.oldest_red),
    .out_oldest_ir  (out_bus.oldest_ir),
    .out_occupancy  (out_bus.occupancy)
  );

endmodule

### rtl/core/dcsr_ctrl.sv
`timescale 1ns / 1ps
`include "dual_channel_sample_ring_unit_macros.svh"
module dcsr_ctrl
  import dcsr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  output ctrl_cmd_t cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.exec  = 1'b1;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_SEND;
      end
      ST_SEND: begin
        // wait until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    out_valid_nxt = (out_valid_r && !out_ready) || cmd.out_load;
  end

  assign out_valid = out_valid_r;

  `DCSR_ASSERT_NEXT(a_accept_then_read, in_valid && in_ready, cmd.rd_en)
  `DCSR_ASSERT_NOW(a_no_result_overwrite, cmd.out_load, !(out_valid_r && !out_ready))
  `DCSR_ASSERT_NEXT(a_load_shows_beat, cmd.out_load, out_valid)

endmodule

### rtl/core/dcsr_dp.sv
`timescale 1ns / 1ps
module dcsr_dp
  import dcsr_pkg::*;
#(
  parameter int RING_SIZE = RING_SIZE_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                cfg_wdata,
  input  ctrl_cmd_t           cmd,
  input  logic [OP_W-1:0]     in_opcode,
  input  logic [BYTE_W-1:0]   in_byte_0,
  input  logic [BYTE_W-1:0]   in_byte_1,
  input  logic [BYTE_W-1:0]   in_byte_2,
  input  logic [BYTE_W-1:0]   in_byte_3,
  input  logic [BYTE_W-1:0]   in_byte_4,
  input  logic [BYTE_W-1:0]   in_byte_5,
  output logic [SAMPLE_W-1:0] out_oldest_red,
  output logic [SAMPLE_W-1:0] out_oldest_ir,
  output logic [OCC_W-1:0]    out_occupancy
);

  localparam int IDX_W  = $clog2(RING_SIZE);
  localparam int DIFF_W = IDX_W + 1;
  localparam int CNT_W  = $clog2(RING_SIZE + 1);
  localparam logic [IDX_W-1:0]  LAST_IDX = IDX_W'(RING_SIZE - 1);
  localparam logic [DIFF_W-1:0] RING_LEN = DIFF_W'(RING_SIZE);

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i);
    return (i == LAST_IDX) ? '0 : i + IDX_W'(1);
  endfunction

  logic                  two_ch_r;
  logic [IDX_W-1:0]      wr_idx_r, wr_idx_nxt;
  logic [IDX_W-1:0]      rd_idx_r, rd_idx_nxt;
  logic [CNT_W-1:0]      fill_cnt_r, fill_cnt_nxt;
  logic [2*SAMPLE_W-1:0] ring_mem [RING_SIZE];
  logic [2*SAMPLE_W-1:0] mem_rd_r;
  logic                  rd_hit_r;
  logic [SAMPLE_W-1:0]   push_red, push_ir;
  logic                  do_push;
  logic [DIFF_W-1:0]     occ_diff;
  logic [SAMPLE_W-1:0]   oldest_red_r, oldest_ir_r;
  logic [OCC_W-1:0]      occupancy_r;
  opcode_t               op;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      two_ch_r <= 1'b0;
    end else if (cfg_we) begin
      two_ch_r <= cfg_wdata;
    end
  end

  assign op       = opcode_t'(in_opcode);
  assign push_red = word18(in_byte_0, in_byte_1, in_byte_2);
  assign push_ir  = two_ch_r ? word18(in_byte_3, in_byte_4, in_byte_5) : '0;
  assign do_push  = cmd.exec && (op == OP_PUSH);

  always_comb begin
    wr_idx_nxt   = wr_idx_r;
    rd_idx_nxt   = rd_idx_r;
    fill_cnt_nxt = fill_cnt_r;
    if (cmd.exec) begin
      unique case (op)
        OP_PUSH: begin
          wr_idx_nxt = wrap_inc(wr_idx_r);
          if (wrap_inc(wr_idx_r) == rd_idx_r) begin
            rd_idx_nxt = wrap_inc(rd_idx_r);  // full: drop oldest
          end
          // entries ever written form a prefix of the ring
          if (CNT_W'(wr_idx_r) == fill_cnt_r) begin
            fill_cnt_nxt = fill_cnt_r + CNT_W'(1);
          end
        end
        OP_POP: begin
          if (wr_idx_r != rd_idx_r) begin
            rd_idx_nxt = wrap_inc(rd_idx_r);
          end
        end
        OP_CLEAR: begin
          wr_idx_nxt = '0;
          rd_idx_nxt = '0;
        end
        OP_NOP: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r   <= '0;
      rd_idx_r   <= '0;
      fill_cnt_r <= '0;
    end else begin
      wr_idx_r   <= wr_idx_nxt;
      rd_idx_r   <= rd_idx_nxt;
      fill_cnt_r <= fill_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ring_mem[wr_idx_r] <= {push_red, push_ir};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      mem_rd_r <= ring_mem[rd_idx_r];
      rd_hit_r <= CNT_W'(rd_idx_r) < fill_cnt_r;
    end
  end

  always_comb begin
    occ_diff = {1'b0, wr_idx_r} - {1'b0, rd_idx_r};
    if (wr_idx_r < rd_idx_r) begin
      occ_diff = occ_diff + RING_LEN;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      oldest_red_r <= rd_hit_r ? mem_rd_r[2*SAMPLE_W-1:SAMPLE_W] : '0;
      oldest_ir_r  <= rd_hit_r ? mem_rd_r[SAMPLE_W-1:0] : '0;
      occupancy_r  <= OCC_W'(occ_diff);
    end
  end

  assign out_oldest_red = oldest_red_r;
  assign out_oldest_ir  = oldest_ir_r;
  assign out_occupancy  = occupancy_r;

endmodule
